// ===== sv/sobel_edge_magnitude_rgb_macros.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sem_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block
`timescale 1ns / 1ps
package sem_pkg;

  localparam int PIX_W      = 24;
  localparam int ROW_W      = 13;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int GRAD_W     = 10;
  localparam int SQ_W       = 21;
  localparam int ROOT_W     = 8;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [ROOT_W-1:0]   SAT_LIMIT    = 8'd255;
  // round(sqrt(s)) reaches 256 exactly from this sum on
  localparam logic [SQ_W-1:0]     SAT_SUM      = 21'd65281;

  typedef struct packed {
    logic       command;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_last;
  } out_item_t;

  // Per-item control decided by the front end
  typedef struct packed {
    logic use_top;
    logic use_mid;
    logic col0;
    logic emit;
    logic last;
  } ctl_t;

endpackage

// ===== sv/sem_front.sv =====
// Front end: frame counters and classification of incoming transactions
`timescale 1ns / 1ps
module sem_front #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic [sem_pkg::WIDTH_W-1:0]        width_i,
  input  logic [sem_pkg::HEIGHT_W-1:0]       height_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sem_pkg::in_item_t                  in_item_i,
  input  logic                               full_i,
  output logic                               push_o,
  output logic [$clog2(MAX_LINE_PIXELS)-1:0] push_addr_o,
  output logic [sem_pkg::PIX_W-1:0]          push_pix_o,
  output sem_pkg::ctl_t                      push_ctl_o
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int EW    = COL_W + 1;
  localparam int CW    = (EW > WIDTH_W) ? EW : WIDTH_W;

  logic [COL_W-1:0] x_q, x_d, ox_q, ox_d;
  logic [ROW_W-1:0] y_q, y_d, oy_q, oy_d;
  logic [EW-1:0]    w;
  logic [HEIGHT_W-1:0] h;
  logic accept, drop, row_live, emit, last;

  // Clamp the frame size registers into range
  always_comb begin
    if (width_i == '0) begin
      w = EW'(1);
    end else if (CW'(width_i) > CW'(MAX_LINE_PIXELS)) begin
      w = EW'(MAX_LINE_PIXELS);
    end else begin
      w = EW'(width_i);
    end
    if (height_i == '0) begin
      h = HEIGHT_W'(1);
    end else if (height_i > HEIGHT_LIMIT) begin
      h = HEIGHT_LIMIT;
    end else begin
      h = height_i;
    end
  end

  // Classify the transaction at the head of the input
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign row_live   = y_q < h;
  assign drop       = row_live && (in_item_i.command == CMD_FLUSH);
  assign emit       = (y_q >= ROW_W'(2)) || ((y_q == ROW_W'(1)) && (x_q != '0));
  assign last       = emit && (({1'b0, oy_q} + 14'd1) >= {1'b0, h})
                           && ((EW'(ox_q) + EW'(1)) >= w);

  assign push_o      = accept && !drop;
  assign push_addr_o = x_q;
  assign push_pix_o  = row_live ? {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue}
                                : '0;
  assign push_ctl_o.use_top = (y_q >= ROW_W'(2)) && ((y_q - ROW_W'(2)) < h);
  assign push_ctl_o.use_mid = (y_q >= ROW_W'(1)) && ((y_q - ROW_W'(1)) < h);
  assign push_ctl_o.col0    = (x_q == '0);
  assign push_ctl_o.emit    = emit;
  assign push_ctl_o.last    = last;

  // Advance input and output positions
  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    ox_d = ox_q;
    oy_d = oy_q;
    if (restart_i) begin
      x_d  = '0;
      y_d  = '0;
      ox_d = '0;
      oy_d = '0;
    end else if (push_o) begin
      if (last) begin
        x_d  = '0;
        y_d  = '0;
        ox_d = '0;
        oy_d = '0;
      end else begin
        if ((EW'(x_q) + EW'(1)) >= w) begin
          x_d = '0;
          y_d = y_q + ROW_W'(1);
        end else begin
          x_d = x_q + COL_W'(1);
        end
        if (emit) begin
          if ((EW'(ox_q) + EW'(1)) >= w) begin
            ox_d = '0;
            oy_d = oy_q + ROW_W'(1);
          end else begin
            ox_d = ox_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      ox_q <= '0;
      oy_q <= '0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
  end

endmodule

// ===== sv/sem_queue.sv =====
// Two-entry queue between the front end and the back end
`timescale 1ns / 1ps
module sem_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);
  import sem_pkg::*;

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== sv/sem_back.sv =====
// Back end: line stores, 3x3 window, gradients, integer square root, output register
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_back #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic                               q_empty_i,
  input  logic [$clog2(MAX_LINE_PIXELS)-1:0] q_addr_i,
  input  logic [sem_pkg::PIX_W-1:0]          q_pix_i,
  input  sem_pkg::ctl_t                      q_ctl_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sem_pkg::out_item_t                 out_item_o
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [PIX_W-1:0] older_mem [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] newer_mem [MAX_LINE_PIXELS];
  logic [PIX_W-1:0] rd_older_q, rd_newer_q;

  logic [COL_W-1:0] cur_addr_q;
  logic [PIX_W-1:0] cur_pix_q;
  ctl_t             cur_ctl_q;

  logic [PIX_W-1:0]  win_q [3][3];
  logic [PIX_W-1:0]  mag_win [3][3];
  logic [PIX_W-1:0]  top, mid;
  logic [GRAD_W-1:0] gx_abs_q [3], gy_abs_q [3];
  logic [GRAD_W-1:0] gx_abs [3], gy_abs [3];
  logic [SQ_W-1:0]   sq_q [3];
  logic [ROOT_W-1:0] root_q [3];
  logic [ROOT_W-1:0] root_next [3];
  logic [ROOT_W-1:0] res [3];
  logic [2:0]        step_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic              out_free;
  logic              win_zero;

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Line stores: read at pop, shift the column down one line in the next cycle
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_older_q <= older_mem[q_addr_i];
      rd_newer_q <= newer_mem[q_addr_i];
    end
    if (state_q == ST_READ) begin
      older_mem[cur_addr_q] <= rd_newer_q;
      newer_mem[cur_addr_q] <= cur_pix_q;
    end
  end

  // Window the magnitude is taken over; an item in column zero sees no right neighbor
  assign top = cur_ctl_q.use_top ? rd_older_q : '0;
  assign mid = cur_ctl_q.use_mid ? rd_newer_q : '0;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag_win[0][r] = win_q[1][r];
      mag_win[1][r] = win_q[2][r];
    end
    mag_win[2][0] = cur_ctl_q.col0 ? '0 : top;
    mag_win[2][1] = cur_ctl_q.col0 ? '0 : mid;
    mag_win[2][2] = cur_ctl_q.col0 ? '0 : cur_pix_q;
  end

  // Gradient magnitudes per channel
  always_comb begin
    logic signed [11:0] gx, gy;
    for (int ch = 0; ch < 3; ch++) begin
      gx = (12'(mag_win[2][0][8*ch +: 8]) + {3'b0, mag_win[2][1][8*ch +: 8], 1'b0}
            + 12'(mag_win[2][2][8*ch +: 8]))
         - (12'(mag_win[0][0][8*ch +: 8]) + {3'b0, mag_win[0][1][8*ch +: 8], 1'b0}
            + 12'(mag_win[0][2][8*ch +: 8]));
      gy = (12'(mag_win[0][2][8*ch +: 8]) + {3'b0, mag_win[1][2][8*ch +: 8], 1'b0}
            + 12'(mag_win[2][2][8*ch +: 8]))
         - (12'(mag_win[0][0][8*ch +: 8]) + {3'b0, mag_win[1][0][8*ch +: 8], 1'b0}
            + 12'(mag_win[2][0][8*ch +: 8]));
      gx_abs[ch] = gx[11] ? GRAD_W'(-gx) : GRAD_W'(gx);
      gy_abs[ch] = gy[11] ? GRAD_W'(-gy) : GRAD_W'(gy);
    end
  end

  // One bit of the square root per cycle, then round to nearest and saturate
  always_comb begin
    logic [ROOT_W-1:0] bit_w, t;
    logic [16:0]       half;
    logic [8:0]        rounded;
    bit_w = ROOT_W'(8'h80 >> step_q);
    for (int ch = 0; ch < 3; ch++) begin
      t = root_q[ch] | bit_w;
      root_next[ch] = (SQ_W'(t * t) <= sq_q[ch]) ? t : root_q[ch];
      half = 17'(root_q[ch] * root_q[ch]) + 17'(root_q[ch]);
      rounded = 9'(root_q[ch]) + ((sq_q[ch] > SQ_W'(half)) ? 9'd1 : 9'd0);
      if (sq_q[ch] >= SAT_SUM || rounded > 9'(SAT_LIMIT)) begin
        res[ch] = SAT_LIMIT;
      end else begin
        res[ch] = rounded[ROOT_W-1:0];
      end
    end
  end

  always_comb begin
    win_zero = 1'b1;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (win_q[c][r] != '0) begin
          win_zero = 1'b0;
        end
      end
    end
  end

  // Sequencer, window and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_addr_q  <= '0;
      cur_pix_q   <= '0;
      cur_ctl_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
        gx_abs_q[c] <= '0;
        gy_abs_q[c] <= '0;
        sq_q[c]     <= '0;
        root_q[c]   <= '0;
      end
    end else begin
      // drop the result once taken, unless a new one is loaded
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i) begin
        for (int c = 0; c < 3; c++) begin
          for (int r = 0; r < 3; r++) begin
            win_q[c][r] <= '0;
          end
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            cur_addr_q <= q_addr_i;
            cur_pix_q  <= q_pix_i;
            cur_ctl_q  <= q_ctl_i;
            state_q    <= ST_READ;
          end
        end
        ST_READ: begin
          for (int ch = 0; ch < 3; ch++) begin
            gx_abs_q[ch] <= gx_abs[ch];
            gy_abs_q[ch] <= gy_abs[ch];
          end
          // advance the window; a new row starts with only the incoming column, and the last item of a frame clears it
          for (int r = 0; r < 3; r++) begin
            win_q[0][r] <= (cur_ctl_q.col0 || cur_ctl_q.last) ? '0 : win_q[1][r];
            win_q[1][r] <= (cur_ctl_q.col0 || cur_ctl_q.last) ? '0 : win_q[2][r];
          end
          win_q[2][0] <= cur_ctl_q.last ? '0 : top;
          win_q[2][1] <= cur_ctl_q.last ? '0 : mid;
          win_q[2][2] <= cur_ctl_q.last ? '0 : cur_pix_q;
          state_q <= cur_ctl_q.emit ? ST_SQUARE : ST_IDLE;
        end
        ST_SQUARE: begin
          for (int ch = 0; ch < 3; ch++) begin
            sq_q[ch]   <= SQ_W'(gx_abs_q[ch] * gx_abs_q[ch])
                        + SQ_W'(gy_abs_q[ch] * gy_abs_q[ch]);
            root_q[ch] <= '0;
          end
          step_q  <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          for (int ch = 0; ch < 3; ch++) begin
            root_q[ch] <= root_next[ch];
          end
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_item_q.out_blue   <= res[0];
            out_item_q.out_green  <= res[1];
            out_item_q.out_red    <= res[2];
            out_item_q.frame_last <= cur_ctl_q.last;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SEM_ASSERT_NEXT(a_root_ends, (state_q == ST_ROOT) && (step_q == 3'd7), state_q == ST_FINISH, "root overran")
  `SEM_ASSERT_NEXT(a_last_clears_window, (state_q == ST_READ) && cur_ctl_q.last, win_zero, "window kept")
  `SEM_ASSERT_NOW(a_result_from_finish, $rose(out_valid_q), $past(state_q == ST_FINISH), "early result")

endmodule

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// Top level of the streaming RGB Sobel edge magnitude block
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i): pixels of a frame in raster
//   order, command = pixel; after the last pixel, flush transactions push out the
//   final row of results. A result for pixel p leaves when input p + width + 1 is
//   taken; frame_last marks the final result of the frame.
//   Output channel (out_valid_o/out_ready_i, out_item_o): one result per emitting
//   input, held stable until taken.
//   Config port (cfg_we_i, cfg_index_i, cfg_data_i): index 0 frame width, index 1
//   frame height; a write restarts the frame. Write only while the block is idle.
// Sequence: an emitting input passes through the back end in order (line store
//   read, window update, squaring, eight square-root steps, rounding); an input
//   that gives no result ends after the window update. The bit-serial square
//   root sets the rate; the back end takes a new input only once it is through with the last one.
// Reset: clears counters, window, queue and output; the line stores are not
//   cleared, as reads are masked by row. Width and height return to 640 x 480.
// Stall: a two-entry queue keeps accepting while the back end works; a stalled
//   output register holds the back end, and the queue then fills and drops ready.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb #(
  parameter int MAX_LINE_PIXELS = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sem_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sem_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sem_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE_PIXELS);
  localparam int Q_W   = COL_W + PIX_W + $bits(ctl_t);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  logic             push, pop, q_empty, q_full;
  logic [COL_W-1:0] push_addr, pop_addr;
  logic [PIX_W-1:0] push_pix, pop_pix;
  ctl_t             push_ctl, pop_ctl;
  logic [Q_W-1:0]   q_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sem_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .full_i      (q_full),
    .push_o      (push),
    .push_addr_o (push_addr),
    .push_pix_o  (push_pix),
    .push_ctl_o  (push_ctl)
  );

  sem_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_ctl, push_pix, push_addr}),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {pop_ctl, pop_pix, pop_addr} = q_out;

  sem_back #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .q_empty_i   (q_empty),
    .q_addr_i    (pop_addr),
    .q_pix_i     (pop_pix),
    .q_ctl_i     (pop_ctl),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
